[rtl/core/dfr_pkg.sv]
package dfr_pkg;

	localparam int RX_FRAME_BYTES = 20;
	localparam int TX_FRAME_BYTES = 14;
	localparam int WP_W = $clog2(RX_FRAME_BYTES + 1);
	localparam int TX_IDX_W = $clog2(TX_FRAME_BYTES);

	localparam logic [7:0] TX_SOF = 8'h02;
	localparam logic [7:0] TX_LEN = 8'h0E;
	localparam logic [7:0] TX_CMD = 8'h01;
	localparam logic [7:0] TX_END = 8'hFF;
	localparam logic [7:0] PAS_MASK = 8'h0F;
	localparam logic [7:0] BIT_MASK = 8'h01;

	localparam logic [TX_IDX_W-1:0] TX_LAST_IDX = TX_IDX_W'(TX_FRAME_BYTES - 1);

	typedef struct packed {
		logic [7:0]  assist_level;
		logic [7:0]  settings_bits;
		logic [7:0]  current_limit;
		logic [15:0] cutoff_voltage_x10;
		logic [15:0] wheel_size_x10;
		logic [7:0]  throttle_sel;
		logic [7:0]  start_delay;
		logic [7:0]  boost_power;
		logic [7:0]  speed_limit;
		logic [7:0]  gear_ratio;
	} settings_t;

	typedef struct packed {
		logic [7:0]  error_code;
		logic        brake_active;
		logic [15:0] motor_current_x10;
		logic [15:0] wheel_period_ms;
	} telemetry_t;

	function automatic logic [7:0] reply_byte(input logic [TX_IDX_W-1:0] idx,
			input telemetry_t t);
		logic [7:0] brk;
		logic [7:0] chk;
		brk = {2'b00, t.brake_active, 5'b00000};
		chk = TX_SOF ^ TX_LEN ^ TX_CMD ^ t.error_code ^ brk
			^ t.motor_current_x10[15:8] ^ t.motor_current_x10[7:0]
			^ t.wheel_period_ms[15:8] ^ t.wheel_period_ms[7:0] ^ TX_END;
		case (idx)
			4'd0:    reply_byte = TX_SOF;
			4'd1:    reply_byte = TX_LEN;
			4'd2:    reply_byte = TX_CMD;
			4'd3:    reply_byte = t.error_code;
			4'd4:    reply_byte = brk;
			4'd6:    reply_byte = t.motor_current_x10[15:8];
			4'd7:    reply_byte = t.motor_current_x10[7:0];
			4'd8:    reply_byte = t.wheel_period_ms[15:8];
			4'd9:    reply_byte = t.wheel_period_ms[7:0];
			4'd12:   reply_byte = TX_END;
			4'd13:   reply_byte = chk;
			default: reply_byte = 8'h00;
		endcase
	endfunction

endpackage

[rtl/core/display_frame_responder.sv]
// A chunk-end item passes through chunk_s1 and busy_q before its first reply byte is loaded
// into the output register. One received byte is taken per cycle while in_stall is low; after a
// chunk-end byte the input stalls for the check (chunk_s1), and while a reply is emitted (busy_q).
// The output register holds a reply byte while out_stall is high.
// Reset (arst_n low, asynchronous) clears the frame store, the write position
// and all handshake state; no clearing pass is needed.
module display_frame_responder
	import dfr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	input  logic        chunk_end,
	input  logic [7:0]  error_code,
	input  logic        brake_active,
	input  logic [15:0] motor_current_x10,
	input  logic [15:0] wheel_period_ms,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  tx_byte,
	output logic        tx_last,
	output logic [7:0]  assist_level,
	output logic [7:0]  settings_bits,
	output logic [7:0]  current_limit,
	output logic [15:0] cutoff_voltage_x10,
	output logic [15:0] wheel_size_x10,
	output logic [7:0]  throttle_sel,
	output logic [7:0]  start_delay,
	output logic [7:0]  boost_power,
	output logic [7:0]  speed_limit,
	output logic [7:0]  gear_ratio
);

	logic [7:0]          store_q [RX_FRAME_BYTES];
	logic [WP_W-1:0]     wp_q;
	logic                chunk_s1;
	telemetry_t          telem_s1;
	telemetry_t          telem_q;
	settings_t           set_q;
	settings_t           set_d;
	settings_t           out_set_q;
	logic                busy_q;
	logic [TX_IDX_W-1:0] idx_q;
	logic                out_valid_q;
	logic [7:0]          tx_byte_q;
	logic                tx_last_q;
	logic [7:0]          xor_d;
	logic                in_acc;
	logic                start;
	logic                out_load;

	assign in_stall = chunk_s1 | busy_q;
	assign in_acc = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RX_FRAME_BYTES; i++) begin
				store_q[i] <= 8'h00;
			end
			wp_q <= '0;
		end else if (in_acc) begin
			for (int i = 0; i < RX_FRAME_BYTES; i++) begin
				if (wp_q == WP_W'(i)) begin
					store_q[i] <= rx_byte;
				end
			end
			if (chunk_end) begin
				wp_q <= '0;
			end else if (wp_q != WP_W'(RX_FRAME_BYTES)) begin
				wp_q <= wp_q + WP_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_s1 <= 1'b0;
		end else begin
			chunk_s1 <= in_acc & chunk_end;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			telem_s1 <= '{error_code, brake_active, motor_current_x10, wheel_period_ms};
		end
	end

	always_comb begin
		xor_d = 8'h00;
		for (int i = 0; i < RX_FRAME_BYTES - 1; i++) begin
			xor_d = xor_d ^ store_q[i];
		end
	end

	always_comb begin
		set_d.assist_level       = {store_q[4][3:0], 4'h0};
		set_d.settings_bits      = {store_q[18][6], store_q[5][1], store_q[5][5],
			store_q[5][6], store_q[18][3:0] & PAS_MASK[3:0]};
		set_d.current_limit      = store_q[13];
		set_d.cutoff_voltage_x10 = {store_q[14], store_q[15]};
		set_d.wheel_size_x10     = {store_q[7], store_q[8]};
		set_d.throttle_sel       = store_q[3];
		set_d.start_delay        = store_q[9];
		set_d.boost_power        = store_q[10];
		set_d.speed_limit        = store_q[12];
		set_d.gear_ratio         = store_q[6];
	end

	assign start = chunk_s1 & (xor_d == store_q[RX_FRAME_BYTES - 1]);
	assign out_load = busy_q & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk) begin
		if (start) begin
			set_q <= set_d;
			telem_q <= telem_s1;
		end
		if (out_load) begin
			tx_byte_q <= reply_byte(idx_q, telem_q);
			tx_last_q <= (idx_q == TX_LAST_IDX) & BIT_MASK[0];
			out_set_q <= set_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (start) begin
				busy_q <= 1'b1;
				idx_q <= '0;
			end else if (out_load) begin
				idx_q <= idx_q + TX_IDX_W'(1);
				if (idx_q == TX_LAST_IDX) begin
					busy_q <= 1'b0;
				end
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign tx_byte            = tx_byte_q;
	assign tx_last            = tx_last_q;
	assign assist_level       = out_set_q.assist_level;
	assign settings_bits      = out_set_q.settings_bits;
	assign current_limit      = out_set_q.current_limit;
	assign cutoff_voltage_x10 = out_set_q.cutoff_voltage_x10;
	assign wheel_size_x10     = out_set_q.wheel_size_x10;
	assign throttle_sel       = out_set_q.throttle_sel;
	assign start_delay        = out_set_q.start_delay;
	assign boost_power        = out_set_q.boost_power;
	assign speed_limit        = out_set_q.speed_limit;
	assign gear_ratio         = out_set_q.gear_ratio;

endmodule

[rtl/core/dfr_checker.sv]
module dfr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        chunk_end,
	input logic        out_valid,
	input logic        out_stall,
	input logic [7:0]  tx_byte,
	input logic        tx_last
);

	// An accepted chunk-end item always stalls the input for the check before more input is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && chunk_end |=> in_stall)
		else $error("input taken during chunk check");

	// While a reply is still incomplete, no new byte may enter.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !tx_last |-> in_stall)
		else $error("input taken during reply");

	// A reply never appears without a preceding chunk-end item.
	assert property (@(posedge clk) disable iff (!arst_n)
		!in_stall |=> !out_valid || $past(out_valid) || $past(in_stall))
		else $error("reply without chunk check");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(tx_byte) && $stable(tx_last))
		else $error("stalled reply item changed");

endmodule

bind display_frame_responder dfr_checker u_dfr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.chunk_end (chunk_end),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.tx_byte   (tx_byte),
	.tx_last   (tx_last)
);
